// ===== design/slope_qrs_detector_top_defines.svh =====
// Assertion macros shared by the slope QRS detector RTL.
// Depends on nothing; expects signals named clk and rst in the including module.
`ifndef SLOPE_QRS_DETECTOR_TOP_DEFINES_SVH
`define SLOPE_QRS_DETECTOR_TOP_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while in reset.
`define SQRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SQRS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define SQRS_ASSERT_IMP(lbl, ante, cons, msg)

`define SQRS_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== design/sqrs_pkg.sv =====
// Types and constants of the slope QRS detector.
// No dependencies; used by the slope filter and the top level.
package sqrs_pkg;

  // Fixed field widths.
  localparam int THR_W       = 15;
  localparam int PERIOD_W    = 12;
  localparam int WIN_W       = 7;
  localparam int WINL_W      = 8;
  localparam int COUNT_W     = 3;
  localparam int CODE_W      = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 15;

  // Number of past samples held by the slope filter.
  localparam int DELAY_DEPTH = 9;

  typedef logic [CODE_W-1:0]      code_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [THR_W-1:0]       thr_t;
  typedef logic [COUNT_W-1:0]     count_t;
  typedef logic signed [WINL_W-1:0] win_t;

  // Result codes.
  localparam code_t CODE_NONE  = 2'd0;
  localparam code_t CODE_BEAT  = 2'd1;
  localparam code_t CODE_NOISE = 2'd2;

  // Configuration register indexes.
  localparam cfg_index_t REG_SLOPE_MIN     = 3'd0;
  localparam cfg_index_t REG_SLOPE_MAX     = 3'd1;
  localparam cfg_index_t REG_SLOPE_INITIAL = 3'd2;
  localparam cfg_index_t REG_ADAPT_PERIOD  = 3'd3;
  localparam cfg_index_t REG_SHORT_WINDOW  = 3'd4;
  localparam cfg_index_t REG_LONG_WINDOW   = 3'd5;

  // Register values after reset.
  localparam thr_t                RST_SLOPE_MIN     = 15'd500;
  localparam thr_t                RST_SLOPE_MAX     = 15'd5000;
  localparam thr_t                RST_SLOPE_INITIAL = 15'd5000;
  localparam logic [PERIOD_W-1:0] RST_ADAPT_PERIOD  = 12'd500;
  localparam logic [WIN_W-1:0]    RST_SHORT_WINDOW  = 7'd40;
  localparam logic [WIN_W-1:0]    RST_LONG_WINDOW   = 7'd50;

  // Sign change counter values.
  localparam count_t COUNT_IDLE     = 3'd0;
  localparam count_t COUNT_FIRST    = 3'd1;
  localparam count_t COUNT_BEAT_MIN = 3'd2;
  localparam count_t COUNT_BEAT_MAX = 3'd4;
  localparam count_t COUNT_SAT      = 3'd5;

  // Lowest value the window counter is held at.
  localparam win_t WIN_FLOOR = -8'sd2;

endpackage

// ===== design/slope_qrs_detector_top.sv =====
// Slope QRS detector: takes one signed ECG sample per transfer and returns one code per
// sample (0 nothing, 1 beat, 2 noise). It accepts a sample every clock cycle unless the
// output stalls. The transfer of a sample loads its slope into the filter register; the
// decision logic that updates the threshold, window and sign-change state then fills the
// output register when that register is free or being read. A stalled output holds the
// pipeline two samples deep. Configuration registers are written through cfg_write/cfg_index/
// cfg_data; the user must write them only while idle, as the block does not enforce this.
`include "slope_qrs_detector_top_defines.svh"

module slope_qrs_detector_top #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [sqrs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sqrs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sqrs_pkg::CODE_W-1:0]         detect_code
);

  // Compare width for magnitudes and thresholds, and width for the retune arithmetic.
  localparam int CW = (SAMPLE_WIDTH + 1 > 16) ? SAMPLE_WIDTH + 1 : 16;
  localparam int RW = ((SAMPLE_WIDTH - 1 > sqrs_pkg::THR_W) ?
                       SAMPLE_WIDTH - 1 : sqrs_pkg::THR_W) + 2;

  // Configuration registers.
  sqrs_pkg::thr_t                        slope_min;
  sqrs_pkg::thr_t                        slope_max;
  sqrs_pkg::thr_t                        slope_initial;
  logic [sqrs_pkg::PERIOD_W-1:0]         adapt_period;
  logic [sqrs_pkg::WIN_W-1:0]            short_window;
  logic [sqrs_pkg::WIN_W-1:0]            long_window;

  // Detector state.
  sqrs_pkg::thr_t                        slope_threshold;
  sqrs_pkg::count_t                      slope_count;
  logic [SAMPLE_WIDTH:0]                 peak_slope;
  sqrs_pkg::win_t                        window_left;
  logic                                  slope_sign;
  logic [sqrs_pkg::PERIOD_W-1:0]         period_count;

  // Pipeline control.
  logic                                  s1_valid;
  logic                                  s1_fire;
  logic                                  in_fire;
  logic signed [SAMPLE_WIDTH-1:0]        slope;

  // Decision logic signals.
  logic signed [SAMPLE_WIDTH:0]          f_ext;
  logic [SAMPLE_WIDTH:0]                 mag;
  logic [CW-1:0]                         mag_cw;
  sqrs_pkg::thr_t                        shrink;
  logic [sqrs_pkg::THR_W:0]              grow;
  sqrs_pkg::thr_t                        thr_a;
  logic [CW-1:0]                         thr_cw;
  logic                                  start;
  sqrs_pkg::count_t                      count1;
  logic                                  sign1;
  sqrs_pkg::win_t                        win1;
  logic signed [SAMPLE_WIDTH:0]          fs;
  logic signed [CW:0]                    fs_w;
  logic signed [CW:0]                    thr_w;
  sqrs_pkg::count_t                      count_next;
  logic                                  slope_sign_next;
  sqrs_pkg::win_t                        win2;
  sqrs_pkg::win_t                        window_left_next;
  logic [SAMPLE_WIDTH:0]                 peak_slope_next;
  logic                                  expire;
  logic                                  beat;
  logic signed [RW-1:0]                  diff;
  logic signed [RW-1:0]                  thr_r;
  sqrs_pkg::thr_t                        thr_tuned;
  sqrs_pkg::thr_t                        slope_threshold_next;
  sqrs_pkg::code_t                       code_next;
  logic [sqrs_pkg::PERIOD_W-1:0]         period_base;
  logic [sqrs_pkg::PERIOD_W-1:0]         period_inc;
  logic [sqrs_pkg::PERIOD_W-1:0]         period_count_next;

  // Handshake: the filter register drains into the output register.
  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;
  assign in_fire  = in_valid && in_ready;

  sqrs_slope_filter #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_filter (
    .clk   (clk),
    .rst   (rst),
    .load  (in_fire),
    .sample(sample),
    .slope (slope)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      slope_min     <= sqrs_pkg::RST_SLOPE_MIN;
      slope_max     <= sqrs_pkg::RST_SLOPE_MAX;
      slope_initial <= sqrs_pkg::RST_SLOPE_INITIAL;
      adapt_period  <= sqrs_pkg::RST_ADAPT_PERIOD;
      short_window  <= sqrs_pkg::RST_SHORT_WINDOW;
      long_window   <= sqrs_pkg::RST_LONG_WINDOW;
    end else if (cfg_write) begin
      case (cfg_index)
        sqrs_pkg::REG_SLOPE_MIN:     slope_min     <= cfg_data;
        sqrs_pkg::REG_SLOPE_MAX:     slope_max     <= cfg_data;
        sqrs_pkg::REG_SLOPE_INITIAL: slope_initial <= cfg_data;
        sqrs_pkg::REG_ADAPT_PERIOD:  adapt_period  <= cfg_data[sqrs_pkg::PERIOD_W-1:0];
        sqrs_pkg::REG_SHORT_WINDOW:  short_window  <= cfg_data[sqrs_pkg::WIN_W-1:0];
        sqrs_pkg::REG_LONG_WINDOW:   long_window   <= cfg_data[sqrs_pkg::WIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Slope magnitude; the most negative value keeps its full magnitude.
  always_comb begin
    f_ext  = (SAMPLE_WIDTH + 1)'(slope);
    mag    = f_ext[SAMPLE_WIDTH] ? $unsigned(-f_ext) : $unsigned(f_ext);
    mag_cw = CW'(mag);
  end

  // Periodic threshold adaptation by one sixteenth, clamped to the limits.
  always_comb begin
    shrink = slope_threshold - (slope_threshold >> 4);
    grow   = {1'b0, slope_threshold} + {1'b0, (slope_threshold >> 4)};
    thr_a  = slope_threshold;
    if (period_count == '0) begin
      if (slope_count == sqrs_pkg::COUNT_IDLE) begin
        thr_a = (shrink < slope_min) ? slope_min : shrink;
      end else if (slope_count >= sqrs_pkg::COUNT_SAT) begin
        thr_a = (grow > {1'b0, slope_max}) ? slope_max : grow[sqrs_pkg::THR_W-1:0];
      end
    end
    thr_cw = CW'(thr_a);
    thr_w  = $signed({1'b0, thr_cw});
  end

  // Slope tracking: window start, sign changes and peak capture.
  always_comb begin
    start  = (slope_count == sqrs_pkg::COUNT_IDLE) && (mag_cw > thr_cw);
    count1 = start ? sqrs_pkg::COUNT_FIRST : slope_count;
    sign1  = start ? !(slope > 0) : slope_sign;
    win1   = start ? $signed({1'b0, short_window}) : window_left;

    fs   = sign1 ? -f_ext : f_ext;
    fs_w = (CW + 1)'(fs);

    count_next      = count1;
    slope_sign_next = sign1;
    win2            = win1;
    peak_slope_next = peak_slope;
    if (count1 != sqrs_pkg::COUNT_IDLE) begin
      if (fs_w < -thr_w) begin
        slope_sign_next = !sign1;
        if (count1 < sqrs_pkg::COUNT_SAT) begin
          count_next = count1 + 3'd1;
        end
        win2 = (count_next > sqrs_pkg::COUNT_BEAT_MAX) ? $signed({1'b0, long_window})
                                                       : $signed({1'b0, short_window});
      end else if ((fs_w > thr_w) && (mag > peak_slope)) begin
        peak_slope_next = mag;
      end
    end
  end

  // Window expiry, beat retune and result code.
  always_comb begin
    expire = (count1 != sqrs_pkg::COUNT_IDLE) && (win2 < 0);
    beat   = expire && (count_next >= sqrs_pkg::COUNT_BEAT_MIN)
                    && (count_next <= sqrs_pkg::COUNT_BEAT_MAX);

    // Move an eighth of the way toward a quarter of the peak, rounding down.
    diff  = $signed(RW'(peak_slope_next >> 2)) - $signed(RW'(thr_a));
    thr_r = $signed(RW'(thr_a)) + (diff >>> 3);
    if (thr_r < $signed(RW'(slope_min))) begin
      thr_tuned = slope_min;
    end else if (thr_r > $signed(RW'(slope_max))) begin
      thr_tuned = slope_max;
    end else begin
      thr_tuned = thr_r[sqrs_pkg::THR_W-1:0];
    end
    slope_threshold_next = beat ? thr_tuned : thr_a;

    code_next = sqrs_pkg::CODE_NONE;
    if (beat) begin
      code_next = sqrs_pkg::CODE_BEAT;
    end else if (expire && (count_next >= sqrs_pkg::COUNT_SAT)) begin
      code_next = sqrs_pkg::CODE_NOISE;
    end

    // The window counts down only while a slope is active.
    window_left_next = window_left;
    if (count1 != sqrs_pkg::COUNT_IDLE) begin
      window_left_next = win2 - 8'sd1;
      if (window_left_next < sqrs_pkg::WIN_FLOOR) begin
        window_left_next = sqrs_pkg::WIN_FLOOR;
      end
    end

    // Period counter runs modulo adapt_period; a beat restarts it.
    period_base       = beat ? '0 : period_count;
    period_inc        = period_base + 12'd1;
    period_count_next = (period_inc >= adapt_period) ? '0 : period_inc;
  end

  // Detector state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      slope_threshold <= sqrs_pkg::RST_SLOPE_INITIAL;
      slope_count     <= sqrs_pkg::COUNT_IDLE;
      peak_slope      <= '0;
      window_left     <= '0;
      slope_sign      <= 1'b0;
      period_count    <= '0;
    end else if (s1_fire) begin
      slope_threshold <= slope_threshold_next;
      slope_count     <= expire ? sqrs_pkg::COUNT_IDLE : count_next;
      peak_slope      <= peak_slope_next;
      window_left     <= window_left_next;
      slope_sign      <= slope_sign_next;
      period_count    <= period_count_next;
    end
  end

  // Filter stage valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      detect_code <= code_next;
    end
  end

  // Assertions.
  `SQRS_ASSERT_IMP(a_count_range, 1'b1, slope_count <= sqrs_pkg::COUNT_SAT, "slope count out of range")
  `SQRS_ASSERT_IMP(a_window_floor, 1'b1, window_left >= sqrs_pkg::WIN_FLOOR, "window below floor")
  `SQRS_ASSERT_NXT(a_code_clears, s1_fire && (code_next != sqrs_pkg::CODE_NONE), slope_count == sqrs_pkg::COUNT_IDLE, "count not cleared after result")
  `SQRS_ASSERT_IMP(a_code_legal, out_valid, detect_code <= sqrs_pkg::CODE_NOISE, "illegal result code")

endmodule

// ===== design/sqrs_slope_filter.sv =====
// Ten-tap slope filter (1,4,6,4,1,-1,-4,-6,-4,-1) with its delay line.
// Depends on sqrs_pkg for the delay depth.
module sqrs_slope_filter #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  output logic signed [SAMPLE_WIDTH-1:0] slope
);

  logic [SAMPLE_WIDTH-1:0] dline [sqrs_pkg::DELAY_DEPTH];
  logic [SAMPLE_WIDTH-1:0] acc;

  // The sum wraps to the sample width, so every term is kept modulo 2^SAMPLE_WIDTH.
  always_comb begin
    acc = sample
        + (dline[0] << 2)
        + (dline[1] << 2) + (dline[1] << 1)
        + (dline[2] << 2)
        + dline[3]
        - dline[4]
        - (dline[5] << 2)
        - ((dline[6] << 2) + (dline[6] << 1))
        - (dline[7] << 2)
        - dline[8];
  end

  // Shift the new sample into the delay line on each transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < sqrs_pkg::DELAY_DEPTH; i++) begin
        dline[i] <= '0;
      end
    end else if (load) begin
      dline[0] <= sample;
      for (int i = 1; i < sqrs_pkg::DELAY_DEPTH; i++) begin
        dline[i] <= dline[i-1];
      end
    end
  end

  // Filter output register.
  always_ff @(posedge clk) begin
    if (load) begin
      slope <= $signed(acc);
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the slope QRS detector top level.
// Depends on sqrs_pkg and slope_qrs_detector_top; predicts each detect code internally.
module testbench;
  import sqrs_pkg::*;

  localparam int SW             = 16;
  localparam int WATCHDOG_LIMIT = 2000;

  // Slope filter coefficients, newest sample first.
  localparam int FILTER_TAPS [10] = '{1, 4, 6, 4, 1, -1, -4, -6, -4, -1};
  // Rough QRS complex shape in sixteenths of the pulse amplitude.
  localparam int QRS_SHAPE [8] = '{1, 4, 10, 16, 6, -6, -3, 0};
  // Hand-picked samples: full-scale steps, filter overflow, unit steps and an impulse.
  localparam int DIRECTED_SAMPLES [24] = '{
    -32768, 32767, -32768, 32767, -32768, 0, 0, 0, 0, 0, 0, 0,
    0, 0, 1, -1, 0, 3000, 0, 0, 0, 0, 0, 0
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  cfg_index_t            cfg_index = REG_SLOPE_MIN;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic signed [SW-1:0]  sample = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [CODE_W-1:0]     detect_code;

  // Idling controls for the two sides.
  bit src_idle  = 1'b1;
  bit sink_idle = 1'b1;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  // Counters for the final summary.
  int n_errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_beats = 0;
  int n_noise = 0;
  int n_settings = 0;

  // Expected detect codes, oldest first.
  code_t expected_codes [$];
  code_t want_code;

  // Shadow copy of the configuration registers.
  int lim_min, lim_max, init_thr, adapt_len, win_short, win_long;

  // Shadow copy of the detector state.
  logic signed [SW-1:0]  tap_hist [DELAY_DEPTH];
  thr_t                  thresh;
  count_t                sign_changes;
  longint                peak_mag;
  win_t                  win_left;
  logic                  neg_slope;
  logic [PERIOD_W-1:0]   adapt_cnt;

  slope_qrs_detector_top #(
    .SAMPLE_WIDTH(SW)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .detect_code(detect_code)
  );

  always #4 clk = ~clk;

  // Load the register defaults and clear the detector state, as reset does.
  function automatic void reset_predictor();
    lim_min   = RST_SLOPE_MIN;
    lim_max   = RST_SLOPE_MAX;
    init_thr  = RST_SLOPE_INITIAL;
    adapt_len = RST_ADAPT_PERIOD;
    win_short = RST_SHORT_WINDOW;
    win_long  = RST_LONG_WINDOW;
    foreach (tap_hist[i]) tap_hist[i] = '0;
    thresh       = RST_SLOPE_INITIAL;
    sign_changes = COUNT_IDLE;
    peak_mag     = 0;
    win_left     = '0;
    neg_slope    = 1'b0;
    adapt_cnt    = '0;
  endfunction

  // Advance the detector model by one sample and return the code it produces.
  function automatic code_t predict_code(input logic signed [SW-1:0] x);
    longint               acc;
    longint               mag;
    longint               thr;
    longint               fs;
    logic signed [SW-1:0] f;
    code_t                code;
    code = CODE_NONE;
    acc  = FILTER_TAPS[0] * longint'(x);
    for (int i = 0; i < DELAY_DEPTH; i++) begin
      acc += FILTER_TAPS[i + 1] * longint'(tap_hist[i]);
    end
    // The filter output wraps to the sample width; its magnitude does not.
    f   = acc[SW-1:0];
    mag = (f < 0) ? -longint'(f) : longint'(f);
    thr = longint'(thresh);

    // Periodic adaptation: shrink when idle, grow while noise is pending.
    if (adapt_cnt == 0) begin
      if (sign_changes == COUNT_IDLE) begin
        thr = thr - (thr >>> 4);
        if (thr < lim_min) thr = lim_min;
      end else if (sign_changes >= COUNT_SAT) begin
        thr = thr + (thr >>> 4);
        if (thr > lim_max) thr = lim_max;
      end
    end

    // A slope above threshold opens a window.
    if (sign_changes == COUNT_IDLE && mag > thr) begin
      sign_changes = COUNT_FIRST;
      win_left     = win_t'(win_short);
      neg_slope    = (f > 0) ? 1'b0 : 1'b1;
    end

    if (sign_changes != COUNT_IDLE) begin
      fs = neg_slope ? -longint'(f) : longint'(f);
      if (fs < -thr) begin
        neg_slope = ~neg_slope;
        if (sign_changes < COUNT_SAT) sign_changes = sign_changes + 1'b1;
        win_left = (sign_changes > COUNT_BEAT_MAX) ? win_t'(win_long) : win_t'(win_short);
      end else if (fs > thr && mag > peak_mag) begin
        peak_mag = mag;
      end
      // Window expiry decides between beat and noise.
      if (win_left < 0) begin
        if (sign_changes >= COUNT_BEAT_MIN && sign_changes <= COUNT_BEAT_MAX) begin
          thr = thr + (((peak_mag >>> 2) - thr) >>> 3);
          if (thr < lim_min) thr = lim_min;
          else if (thr > lim_max) thr = lim_max;
          code      = CODE_BEAT;
          adapt_cnt = '0;
        end else if (sign_changes >= COUNT_SAT) begin
          code = CODE_NOISE;
        end
        sign_changes = COUNT_IDLE;
      end
      win_left = win_left - 8'sd1;
      if (win_left < WIN_FLOOR) win_left = WIN_FLOOR;
    end

    thresh = thr[THR_W-1:0];
    for (int i = DELAY_DEPTH - 1; i > 0; i--) begin
      tap_hist[i] = tap_hist[i - 1];
    end
    tap_hist[0] = x;
    adapt_cnt = adapt_cnt + 1'b1;
    if (adapt_cnt >= adapt_len) adapt_cnt = '0;
    return code;
  endfunction

  // Send one sample, with an optional idle burst first, and record its expected code.
  task automatic send_sample(input logic signed [SW-1:0] value);
    if (src_idle && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= value;
    do @(posedge clk); while (!in_ready);
    expected_codes.push_back(predict_code(value));
    n_sent++;
  endtask

  // Stop sending and wait until every expected code has been transferred.
  task automatic wait_results_done();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_codes.size() != 0);
  endtask

  // Write one configuration register and update the shadow copy.
  task automatic write_reg(input cfg_index_t idx, input int value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_SLOPE_MIN:     lim_min   = value & 'h7FFF;
      REG_SLOPE_MAX:     lim_max   = value & 'h7FFF;
      REG_SLOPE_INITIAL: init_thr  = value & 'h7FFF;
      REG_ADAPT_PERIOD:  adapt_len = value & 'hFFF;
      REG_SHORT_WINDOW:  win_short = value & 'h7F;
      REG_LONG_WINDOW:   win_long  = value & 'h7F;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Drain the pipeline, then write all six registers.
  task automatic apply_settings(input int s_min, input int s_max, input int s_init,
                                input int period, input int w_short, input int w_long);
    wait_results_done();
    write_reg(REG_SLOPE_MIN, s_min);
    write_reg(REG_SLOPE_MAX, s_max);
    write_reg(REG_SLOPE_INITIAL, s_init);
    write_reg(REG_ADAPT_PERIOD, period);
    write_reg(REG_SHORT_WINDOW, w_short);
    write_reg(REG_LONG_WINDOW, w_long);
    n_settings++;
  endtask

  // ECG-like stream: QRS pulses, quiet baseline, alternating noise bursts and raw words.
  task automatic send_heartbeat_stream(input int count, input int noise_pct);
    int                   sent;
    int                   kind;
    int                   len;
    int                   amp;
    int                   k;
    logic signed [SW-1:0] v;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        len = $urandom_range(1, 4);
        for (k = 0; k < len && sent < count; k++) begin
          v = SW'($urandom_range(0, 65535));
          send_sample(v);
          sent++;
        end
      end else if (kind < 10 + noise_pct) begin
        len = $urandom_range(4, 14);
        for (k = 0; k < len && sent < count; k++) begin
          amp = $urandom_range(1000, 32767);
          v   = SW'((k % 2 == 0) ? amp : -amp);
          send_sample(v);
          sent++;
        end
      end else if (kind < 50 + noise_pct) begin
        amp = $urandom_range(300, 12000);
        if ($urandom_range(0, 1) == 1) amp = -amp;
        for (k = 0; k < 8 && sent < count; k++) begin
          v = SW'(amp * QRS_SHAPE[k] / 16 + int'($urandom_range(0, 100)) - 50);
          send_sample(v);
          sent++;
        end
      end else begin
        len = $urandom_range(3, 30);
        for (k = 0; k < len && sent < count; k++) begin
          v = SW'(int'($urandom_range(0, 400)) - 200);
          send_sample(v);
          sent++;
        end
      end
    end
  endtask

  // Pick a random register setting, sometimes at the edges of each range.
  task automatic apply_random_settings();
    int s_min, s_max, s_init, period, w_short, w_long;
    s_min  = ($urandom_range(0, 7) == 0) ? 32767 : $urandom_range(0, 3000);
    s_max  = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(2000, 32767);
    s_init = $urandom_range(0, 32767);
    case ($urandom_range(0, 3))
      0:       period = $urandom_range(0, 1);
      1:       period = $urandom_range(1, 4095);
      default: period = $urandom_range(2, 60);
    endcase
    w_short = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 20);
    w_long  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 20);
    apply_settings(s_min, s_max, s_init, period, w_short, w_long);
  endtask

  // Full-scale samples, filter overflow, zero window and a zero adaptation period.
  task automatic test_directed();
    apply_settings(0, 32767, 5000, 0, 0, 1);
    foreach (DIRECTED_SAMPLES[i]) begin
      send_sample(SW'(DIRECTED_SAMPLES[i]));
    end
  endtask

  // Register defaults written back explicitly, with a normal rhythm.
  task automatic test_reset_settings();
    apply_settings(RST_SLOPE_MIN, RST_SLOPE_MAX, RST_SLOPE_INITIAL,
                   RST_ADAPT_PERIOD, RST_SHORT_WINDOW, RST_LONG_WINDOW);
    send_heartbeat_stream(150, 15);
  endtask

  // Lower clamp above the upper one, then both at opposite extremes.
  task automatic test_crossed_limits();
    apply_settings(20000, 1000, 0, 7, 3, 5);
    send_heartbeat_stream(60, 20);
    apply_settings(32767, 0, 32767, 2, 1, 2);
    send_heartbeat_stream(60, 20);
  endtask

  // Longest windows with adaptation on every sample, so noise pushes the threshold
  // into its upper clamp; then the longest period with a zero long window.
  task automatic test_window_limits();
    apply_settings(0, 32767, 32767, 1, 127, 127);
    send_heartbeat_stream(100, 50);
    apply_settings(0, 32767, 0, 4095, 127, 0);
    send_heartbeat_stream(60, 20);
  endtask

  // The period counter is left above the new period and has to wrap.
  task automatic test_period_wrap();
    apply_settings(100, 20000, 5000, 3, 5, 8);
    send_heartbeat_stream(60, 15);
  endtask

  // Several random settings with random rhythm.
  task automatic test_random_settings();
    repeat (5) begin
      apply_random_settings();
      send_heartbeat_stream(50, $urandom_range(5, 30));
    end
  endtask

  // Back-to-back transfers on both sides.
  task automatic test_full_rate();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    apply_random_settings();
    send_heartbeat_stream(120, 15);
  endtask

  // Receiver readiness: random stall bursts while enabled.
  always @(posedge clk) begin
    if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready   <= 1'b0;
    end else if (sink_idle && $urandom_range(0, 5) == 0) begin
      hold_cycles <= $urandom_range(0, 5);
      out_ready   <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare every result transfer with the oldest expected code.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_codes.size() == 0) begin
        $display("%0t: detect_code %0d transferred with nothing expected", $time, detect_code);
        n_errors++;
      end else begin
        want_code = expected_codes.pop_front();
        n_checked++;
        if (want_code == CODE_BEAT) n_beats++;
        if (want_code == CODE_NOISE) n_noise++;
        if (detect_code !== want_code) begin
          $display("%0t: detect_code mismatch, expected %0d, actual %0d",
                   $time, want_code, detect_code);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no transfer for %0d cycles", $time, quiet_cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    reset_predictor();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_reset_settings();
    test_crossed_limits();
    test_window_limits();
    test_period_wrap();
    test_random_settings();
    test_full_rate();
    wait_results_done();
    repeat (6) @(posedge clk);
    $display("Sent %0d samples under %0d register settings, including crossed clamps,",
             n_sent, n_settings);
    $display("window and period extremes; checked %0d codes (%0d beats, %0d noise).",
             n_checked, n_beats, n_noise);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
